[hdl/slpq_pkg.sv]
package slpq_pkg;

  localparam int PitchW  = 7;
  localparam int MaskW   = 12;
  localparam int ModeW   = 2;
  localparam int ClassW  = 4;
  localparam int CfgIdxW = 1;

  localparam logic [PitchW-1:0] PitchMax   = PitchW'(127);
  localparam logic [ClassW-1:0] ClassLast  = ClassW'(11);
  localparam logic [MaskW-1:0]  MaskReset  = MaskW'(12'hFFF);

  typedef enum logic [ModeW-1:0] {
    MODE_OFF     = 2'd0,
    MODE_NEAREST = 2'd1,
    MODE_UP      = 2'd2,
    MODE_DOWN    = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALE_MASK = 1'b0,
    REG_LOCK_MODE  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

[hdl/scale_lock_pitch_quantizer_unit.sv]
// Off mode: the result is presented in the cycle after the input transfer.
// Locking modes: candidate pitches 0..127 are scanned in turn through a
// single subtract/compare unit, then the result is presented.
// A new note is taken only in idle, after the previous result is accepted.
// Reset: synchronous, active high; scale_mask returns to all classes set,
// lock_mode to off, and the block is idle with no result pending.
module scale_lock_pitch_quantizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [slpq_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [slpq_pkg::MaskW-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slpq_pkg::PitchW-1:0]     note_pitch,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slpq_pkg::PitchW-1:0]     locked_pitch,
  output logic                            no_candidate
);
  import slpq_pkg::*;

  logic [MaskW-1:0]  scale_mask;
  mode_t             lock_mode;
  state_t            state;
  logic [PitchW-1:0] pitch;
  logic [PitchW-1:0] cand;
  logic [ClassW-1:0] cls;
  logic [PitchW-1:0] best;
  logic [PitchW-1:0] best_dist;
  logic              found;

  logic              cand_in_scale;
  logic              cand_ge;
  logic [PitchW-1:0] delta;
  logic              dir_ok;
  logic              take;
  logic              found_next;
  logic [PitchW-1:0] best_next;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mask <= MaskReset;
      lock_mode  <= MODE_OFF;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_SCALE_MASK: scale_mask <= cfg_data;
        REG_LOCK_MODE:  lock_mode  <= mode_t'(cfg_data[ModeW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    cand_in_scale = scale_mask[cls];
    cand_ge       = (cand >= pitch);
    delta         = cand_ge ? (cand - pitch) : (pitch - cand);
    case (lock_mode)
      MODE_UP:   dir_ok = cand_ge;
      MODE_DOWN: dir_ok = (cand <= pitch);
      default:   dir_ok = 1'b1;
    endcase
    take = cand_in_scale && dir_ok &&
           (!found || (delta < best_dist) ||
            ((lock_mode == MODE_NEAREST) && (delta == best_dist)));
    found_next = found || take;
    best_next  = take ? cand : best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= (lock_mode == MODE_OFF) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cand == PitchMax) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pitch        <= note_pitch;
        cand         <= '0;
        cls          <= '0;
        found        <= 1'b0;
        best         <= '0;
        best_dist    <= '0;
        locked_pitch <= note_pitch;
        no_candidate <= 1'b0;
      end
      ST_SCAN: begin
        cand  <= cand + PitchW'(1);
        cls   <= (cls == ClassLast) ? '0 : cls + ClassW'(1);
        found <= found_next;
        best  <= best_next;
        if (take) begin
          best_dist <= delta;
        end
        if (cand == PitchMax) begin
          locked_pitch <= found_next ? best_next : pitch;
          no_candidate <= !found_next;
        end
      end
      default: ;
    endcase
  end

  a_off_bypass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && lock_mode == MODE_OFF) |=> out_valid)
    else $error("off mode result not presented next cycle");

  a_flag_returns_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_candidate) |-> (locked_pitch == pitch))
    else $error("flagged result differs from input pitch");

  a_up_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !no_candidate && lock_mode == MODE_UP) |-> (locked_pitch >= pitch))
    else $error("round up result below input");

  a_down_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !no_candidate && lock_mode == MODE_DOWN) |-> (locked_pitch <= pitch))
    else $error("round down result above input");

  a_result_in_scale: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !no_candidate && lock_mode != MODE_OFF && locked_pitch != pitch)
      |-> found)
    else $error("moved pitch without a candidate");

endmodule

[test/tb_scale_lock_pitch_quantizer_unit.sv]
module tb_scale_lock_pitch_quantizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import slpq_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 140;
  localparam int PhaseCount = 13;
  localparam int PhaseItems = 140;

  typedef struct packed {
    logic [PitchW-1:0] pitch;
    logic              miss;
  } lock_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [MaskW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [PitchW-1:0]  note_pitch;
  logic               out_valid;
  logic               out_stall;
  logic [PitchW-1:0]  locked_pitch;
  logic               no_candidate;

  logic rx_wait = 1'b0;
  logic rx_hold = 1'b0;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;

  logic [MaskW-1:0] model_mask;
  mode_t            model_mode;
  lock_result_t     expected_locks[$];
  int               mismatches = 0;
  int               cycle_count = 0;
  event             hold_start;

  assign out_stall = rx_wait | rx_hold;

  scale_lock_pitch_quantizer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .note_pitch  (note_pitch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .locked_pitch(locked_pitch),
    .no_candidate(no_candidate)
  );

  always #1 clk = ~clk;

  function automatic lock_result_t lock_pitch(input logic [PitchW-1:0] p,
                                              input logic [MaskW-1:0] mask,
                                              input mode_t mode);
    lock_result_t r;
    int           pi;
    int           c;
    int           delta;
    int           best_dist;
    bit           found;
    pi        = int'(p);
    r.pitch   = p;
    r.miss    = 1'b0;
    found     = 1'b0;
    best_dist = 0;
    if (mode == MODE_OFF || mask[pi % 12]) begin
      return r;
    end
    for (c = 0; c <= int'(PitchMax); c++) begin
      if (!mask[c % 12]) continue;
      if (mode == MODE_UP && c < pi) continue;
      if (mode == MODE_DOWN && c > pi) continue;
      delta = (c >= pi) ? c - pi : pi - c;
      if (!found || delta < best_dist || (mode == MODE_NEAREST && delta == best_dist)) begin
        r.pitch   = c[PitchW-1:0];
        best_dist = delta;
        found     = 1'b1;
      end
    end
    if (!found) begin
      r.miss = 1'b1;
    end
    return r;
  endfunction

  task automatic send_note(input logic [PitchW-1:0] p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    note_pitch <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    expected_locks.push_back(lock_pitch(p, model_mask, model_mode));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_locks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [MaskW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SCALE_MASK: model_mask = data;
      REG_LOCK_MODE:  model_mode = mode_t'(data[ModeW-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // drain, then load both registers; mode data may carry junk upper bits
  task automatic set_scale(input logic [MaskW-1:0] mask, input logic [MaskW-1:0] mode_data);
    wait_drained();
    write_reg(REG_SCALE_MASK, mask);
    write_reg(REG_LOCK_MODE, mode_data);
  endtask

  task automatic test_reset_defaults();
    send_note(7'd0);
    send_note(PitchMax);
    send_note(7'd64);
    wait_drained();
  endtask

  task automatic test_directed_cases();
    set_scale(12'h000, {10'd0, MODE_OFF});
    send_note(7'd5);
    set_scale(12'h000, {10'd0, MODE_NEAREST});
    send_note(7'd0);
    send_note(PitchMax);
    set_scale(12'h001, {10'd0, MODE_NEAREST});
    send_note(7'd6);
    send_note(PitchMax);
    send_note(7'd0);
    send_note(7'd5);
    set_scale(12'h800, {10'd0, MODE_NEAREST});
    send_note(7'd0);
    send_note(PitchMax);
    set_scale(12'h001, {10'd0, MODE_UP});
    send_note(PitchMax);
    send_note(7'd121);
    send_note(7'd1);
    set_scale(12'h800, {10'd0, MODE_DOWN});
    send_note(7'd0);
    send_note(7'd10);
    send_note(7'd12);
    set_scale(12'h001, 12'hFFF);
    send_note(PitchMax);
    set_scale(12'hFFF, 12'hFF5);
    send_note(7'd77);
    wait_drained();
  endtask

  task automatic test_hold_off();
    int i;
    tx_idle = 1'b0;
    set_scale(12'(($urandom_range(0, 4095))), {10'd0, MODE_OFF});
    -> hold_start;
    for (i = 0; i < 6; i++) begin
      send_note(7'($urandom_range(0, 127)));
    end
    set_scale(12'hAB5, {10'($urandom_range(0, 1023)), MODE_NEAREST});
    -> hold_start;
    for (i = 0; i < 6; i++) begin
      send_note(7'($urandom_range(0, 127)));
    end
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_phases();
    int               phase;
    int               i;
    int               pick;
    logic [MaskW-1:0] mask;
    logic [PitchW-1:0] p;
    for (phase = 0; phase < PhaseCount; phase++) begin
      case ($urandom_range(0, 5))
        0: mask = 12'h000;
        1: mask = 12'hFFF;
        2: mask = 12'h001 << $urandom_range(0, 11);
        3: mask = (12'h001 << $urandom_range(0, 11)) | (12'h001 << $urandom_range(0, 11));
        4: mask = 12'hAB5;
        default: mask = 12'($urandom_range(0, 4095));
      endcase
      set_scale(mask, {10'($urandom_range(0, 1023)), ModeW'(phase % 4)});
      tx_idle = (phase % 3 != 0);
      rx_idle = (phase % 3 != 1);
      for (i = 0; i < PhaseItems; i++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          p = 7'($urandom_range(0, 11));
        end else if (pick == 1) begin
          p = 7'($urandom_range(116, 127));
        end else begin
          p = 7'($urandom_range(0, 127));
        end
        send_note(p);
      end
    end
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : rx_side
    int rx_gap;
    forever begin
      rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (rx_gap > 0) begin
        rx_wait <= 1'b1;
        repeat (rx_gap) @(negedge clk);
      end
      rx_wait <= 1'b0;
      @(posedge clk);
      while (!(out_valid === 1'b1 && out_stall === 1'b0 && rst === 1'b0)) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : rx_hold_off
    forever begin
      @(hold_start);
      rx_hold <= 1'b1;
      repeat (HoldCycles) @(negedge clk);
      rx_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    lock_result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_locks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: locked_pitch %0d no_candidate %0b",
                   locked_pitch, no_candidate);
        end
      end else begin
        want = expected_locks.pop_front();
        if (locked_pitch !== want.pitch || no_candidate !== want.miss) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: locked_pitch exp %0d got %0d, no_candidate exp %0b got %0b",
                     want.pitch, locked_pitch, want.miss, no_candidate);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_scale_lock_pitch_quantizer_unit failed");
    $finish;
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_SCALE_MASK;
    cfg_data   = '0;
    in_valid   = 1'b0;
    note_pitch = '0;
    model_mask = MaskReset;
    model_mode = MODE_OFF;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_hold_off();
    test_random_phases();
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && expected_locks.size() == 0) begin
      $display("tb_scale_lock_pitch_quantizer_unit passed");
    end else begin
      $display("tb_scale_lock_pitch_quantizer_unit failed");
    end
    $finish;
  end

endmodule
